// File: src/sitda_pkg.sv
// Package for the signed integer to decimal ASCII converter.
// Holds the character codes, the character type and shared sizing constants.
// No dependencies.
package sitda_pkg;

  localparam int DefInputBits = 32;
  localparam int CharW = 7;
  localparam int DdSteps = 4;

  typedef logic [CharW-1:0] char_t;

  localparam char_t AsciiMinus = 7'd45;
  localparam char_t AsciiZero = 7'd48;

endpackage

// File: src/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII converter, top level.
// Depends on sitda_pkg for character codes and sizing constants.
//
// Usage: the input channel (in_valid_i, in_stall_o, number_i) takes one signed
// two's complement number per transaction. The output channel (out_valid_o,
// out_stall_i, char_code_o, last_char_o) returns its decimal text, one ASCII
// character per transaction: a '-' first for a negative value, then the digits
// from the most significant down without leading zeros, or a single '0' for zero.
// last_char_o marks the final character of each number.
// A first register stage takes the magnitude; a chain of shift-add-3 stages,
// four bit steps each, converts it to BCD (8 stages at 32 bits). A number
// accepted at an idle block passes the magnitude register, the conversion
// stages and the serializer before its first character shows. The pipeline
// accepts a number in every cycle while it has room; the serializer takes one
// number at a time and holds the stages until that number's last character is issued.
// A stalled output holds its character unchanged and the stall travels back
// stage by stage to in_stall_o; nothing is lost or repeated.
// Reset clears all valid bits and the serializer; no clearing pass is needed.
module signed_int_to_decimal_ascii #(
  parameter int INPUT_BITS = sitda_pkg::DefInputBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [INPUT_BITS-1:0] number_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [sitda_pkg::CharW-1:0]  char_code_o,
  output logic                         last_char_o
);

  localparam int NDig = ((((INPUT_BITS - 1) * 1233) >> 12) + 1);
  localparam int BcdW = 4 * NDig;
  localparam int NStg = (INPUT_BITS + sitda_pkg::DdSteps - 1) / sitda_pkg::DdSteps;
  localparam int IdxW = $clog2(NDig);

  logic                  vld_q [0:NStg];
  logic                  neg_q [0:NStg];
  logic [INPUT_BITS-1:0] mag_q [0:NStg];
  logic [BcdW-1:0]       bcd_q [0:NStg];
  logic                  rdy   [0:NStg+1];

  logic                  ser_busy_q;
  logic                  ser_minus_q;
  logic [IdxW-1:0]       ser_idx_q;
  logic [BcdW-1:0]       ser_bcd_q;
  logic                  out_valid_q;
  sitda_pkg::char_t      char_q;
  logic                  last_q;

  logic                  load;
  logic                  emit;
  logic [IdxW-1:0]       lead_idx;
  logic [3:0]            cur_digit;
  logic [INPUT_BITS-1:0] raw;
  logic [INPUT_BITS-1:0] mag_in;

  always_comb begin
    rdy[NStg+1] = !ser_busy_q;
    for (int s = NStg; s >= 0; s--) begin
      rdy[s] = !vld_q[s] || rdy[s+1];
    end
  end

  assign in_stall_o = !rdy[0];
  assign raw = number_i;
  assign mag_in = raw[INPUT_BITS-1] ? (~raw + {{(INPUT_BITS-1){1'b0}}, 1'b1}) : raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      neg_q[0] <= raw[INPUT_BITS-1];
      mag_q[0] <= mag_in;
      bcd_q[0] <= '0;
    end
  end

  for (genvar s = 1; s <= NStg; s++) begin : g_stage
    logic [BcdW-1:0]       bcd_d;
    logic [INPUT_BITS-1:0] mag_d;

    always_comb begin
      logic [BcdW-1:0]       b;
      logic [INPUT_BITS-1:0] m;
      b = bcd_q[s-1];
      m = mag_q[s-1];
      for (int j = 0; j < sitda_pkg::DdSteps; j++) begin
        if ((s - 1) * sitda_pkg::DdSteps + j < INPUT_BITS) begin
          for (int d = 0; d < NDig; d++) begin
            if (b[4*d +: 4] >= 4'd5) begin
              b[4*d +: 4] = b[4*d +: 4] + 4'd3;
            end
          end
          b = {b[BcdW-2:0], m[INPUT_BITS-1]};
          m = {m[INPUT_BITS-2:0], 1'b0};
        end
      end
      bcd_d = b;
      mag_d = m;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld_q[s] <= vld_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s] && vld_q[s-1]) begin
        neg_q[s] <= neg_q[s-1];
        mag_q[s] <= mag_d;
        bcd_q[s] <= bcd_d;
      end
    end
  end

  always_comb begin
    lead_idx = '0;
    for (int d = 0; d < NDig; d++) begin
      if (bcd_q[NStg][4*d +: 4] != 4'd0) begin
        lead_idx = IdxW'(d);
      end
    end
  end

  assign load = vld_q[NStg] && !ser_busy_q;
  assign emit = ser_busy_q && (!out_valid_q || !out_stall_i);
  assign cur_digit = ser_bcd_q[{ser_idx_q, 2'b00} +: 4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_busy_q  <= 1'b0;
      ser_minus_q <= 1'b0;
      ser_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        ser_busy_q  <= 1'b1;
        ser_minus_q <= neg_q[NStg];
        ser_idx_q   <= lead_idx;
      end else if (emit) begin
        if (ser_minus_q) begin
          ser_minus_q <= 1'b0;
        end else if (ser_idx_q == '0) begin
          ser_busy_q <= 1'b0;
        end else begin
          ser_idx_q <= ser_idx_q - 1'b1;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ser_bcd_q <= bcd_q[NStg];
    end
    if (emit) begin
      if (ser_minus_q) begin
        char_q <= sitda_pkg::AsciiMinus;
        last_q <= 1'b0;
      end else begin
        char_q <= sitda_pkg::AsciiZero + {3'b000, cur_digit};
        last_q <= (ser_idx_q == '0);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;

  a_last_not_minus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_char_o |-> char_code_o != sitda_pkg::AsciiMinus)
    else $error("Minus sign flagged as last character.");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && char_code_o != sitda_pkg::AsciiMinus |->
      char_code_o >= sitda_pkg::AsciiZero && char_code_o <= sitda_pkg::AsciiZero + 7'd9)
    else $error("Character is neither a sign nor a digit.");

  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> ser_busy_q)
    else $error("Serializer not busy after load.");

  a_minus_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && ser_minus_q |=> out_valid_o && char_code_o == sitda_pkg::AsciiMinus)
    else $error("Pending sign was not emitted first.");

  a_idle_no_minus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ser_busy_q |-> !ser_minus_q)
    else $error("Sign pending while the serializer is idle.");

endmodule

// File: sim/decimal_text_checker.sv
`timescale 1ns / 1ps
// Checker for the signed integer to decimal ASCII converter: watches both channels,
// predicts the character text of every accepted number and compares it in order.
// Depends on sitda_pkg for the character type and the character codes.
module decimal_text_checker #(
  parameter int NumW = sitda_pkg::DefInputBits
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic signed [NumW-1:0] number_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  sitda_pkg::char_t       char_code_i,
  input  logic                   last_char_i,
  output int                     fail_count_o,
  output int                     pending_o
);
  import sitda_pkg::*;

  typedef struct packed {
    char_t code;
    logic  last;
  } text_char_t;

  text_char_t expected_chars[$];
  int         fail_cnt = 0;

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

  function automatic void push_decimal_text(logic signed [NumW-1:0] number);
    logic [NumW-1:0] mag;
    char_t           digits[$];
    text_char_t      rec;
    mag = number[NumW-1] ? ~number + 1'b1 : number;
    if (number[NumW-1]) begin
      rec.code = AsciiMinus;
      rec.last = 1'b0;
      expected_chars.push_back(rec);
    end
    if (mag == '0) begin
      rec.code = AsciiZero;
      rec.last = 1'b1;
      expected_chars.push_back(rec);
      return;
    end
    while (mag != '0) begin
      digits.push_front(AsciiZero + char_t'(mag % 10));
      mag = mag / 10;
    end
    foreach (digits[i]) begin
      rec.code = digits[i];
      rec.last = (i == digits.size() - 1);
      expected_chars.push_back(rec);
    end
  endfunction

  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected character: char_code %0d last_char %0b", char_code_i, last_char_i);
          fail_cnt++;
        end else begin
          want = expected_chars.pop_front();
          if (char_code_i !== want.code) begin
            $error("char_code: expected %0d, actual %0d", want.code, char_code_i);
            fail_cnt++;
          end
          if (last_char_i !== want.last) begin
            $error("last_char: expected %0b, actual %0b", want.last, last_char_i);
            fail_cnt++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        push_decimal_text(number_i);
      end
    end
    fail_count_o <= fail_cnt;
    pending_o <= expected_chars.size();
  end

endmodule

// File: sim/signed_int_to_decimal_ascii_tb.sv
`timescale 1ns / 1ps
// Testbench top for the signed integer to decimal ASCII converter: drives numbers
// and output stalls, and gives the verdict. Depends on sitda_pkg, the converter
// and decimal_text_checker.
module signed_int_to_decimal_ascii_tb;
  import sitda_pkg::*;

  localparam int NumW = DefInputBits;
  localparam int IdleLimit = 5000;
  localparam int RandomItems = 300;
  localparam longint MaxNum = (longint'(1) << (NumW - 1)) - 1;
  localparam longint MinNum = -MaxNum - 1;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic signed [NumW-1:0] number = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  char_t                  char_code;
  logic                   last_char;
  int                     fail_count;
  int                     pending;
  int                     idle_cycles = 0;
  bit                     calm = 1'b0;

  always #10 clk = ~clk;

  signed_int_to_decimal_ascii #(
    .INPUT_BITS(NumW)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .number_i   (number),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .char_code_o(char_code),
    .last_char_o(last_char)
  );

  decimal_text_checker #(
    .NumW(NumW)
  ) u_chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .number_i    (number),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .char_code_i (char_code),
    .last_char_i (last_char),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic signed [NumW-1:0] random_number();
    int     kind;
    int     digs;
    longint pow;
    longint lo;
    longint hi;
    longint v;
    kind = $urandom_range(0, 3);
    case (kind)
      0: begin
        v = longint'($urandom());
      end
      3: begin
        if ($urandom_range(0, 1)) begin
          v = MaxNum - $urandom_range(0, 20);
        end else begin
          v = MinNum + $urandom_range(0, 20);
        end
      end
      default: begin
        digs = $urandom_range(1, 10);
        pow = 1;
        repeat (digs - 1) pow = pow * 10;
        lo = (digs == 1) ? 0 : pow;
        hi = pow * 10 - 1;
        if (hi > MaxNum) hi = MaxNum;
        v = lo + $urandom_range(0, int'(hi - lo));
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return NumW'(v);
  endfunction

  task automatic send_number(input logic signed [NumW-1:0] value, input bit allow_gap);
    int gap;
    gap = allow_gap ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    number <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int n;
    wait (rst_n);
    forever begin
      if ($urandom_range(0, 9) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(50, 150)) @(posedge clk);
      end
      n = pick_gap();
      out_stall <= (n > 0);
      repeat ((n > 0) ? n : 1) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    longint directed[];
    directed = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 7, 1000000000,
                 999999999, -999999999, 1234567890, -1234567890, 1000000009,
                 64'h55555555, 64'hAAAAAAAA, MaxNum, MaxNum - 1, MinNum,
                 MinNum + 1};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) begin
      send_number(NumW'(directed[i]), (i % 3) == 0);
    end
    wait_drained();
    for (int i = 0; i < RandomItems; i++) begin
      if ((i % 40) == 0) calm = ($urandom_range(0, 2) == 0);
      if (i > 0 && (i % 100) == 0) wait_drained();
      send_number(random_number(), !calm);
    end
    wait_drained();
    repeat (30) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
